// ===== sv/srec_pkg.sv =====
`default_nettype none

package srec_pkg;

  // Line parser modes
  typedef enum logic [1:0] {
    LM_START  = 2'd0,  // waiting for the first character of a line
    LM_SAW_S  = 2'd1,  // first character was 'S'
    LM_RECORD = 2'd2,  // reading an S3-layout record
    LM_SKIP   = 2'd3   // ignore the rest of the line
  } line_mode_e;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_DATA     = 3'd0,
    KIND_OK       = 3'd1,
    KIND_MISMATCH = 3'd2,
    KIND_TRUNC    = 3'd3,
    KIND_EOF      = 3'd4
  } kind_e;

  // Input command codes
  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_EOF  = 1'b1;

  localparam logic [7:0] CHAR_S    = 8'h53;  // 'S'
  localparam logic [7:0] CHAR_0    = 8'h30;  // '0'
  localparam logic [7:0] CHAR_5    = 8'h35;  // '5'
  localparam logic [7:0] CHAR_7    = 8'h37;  // '7'
  localparam logic [7:0] CHAR_9    = 8'h39;  // '9'
  localparam logic [7:0] CHAR_A    = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_F    = 8'h46;  // 'F'
  localparam logic [7:0] HDR_BYTES = 8'd5;   // 4 address bytes + checksum

  localparam int unsigned CPOS_W = 4;
  localparam logic [CPOS_W-1:0] CPOS_COUNT = 4'd3;   // odd char that closes the count
  localparam logic [CPOS_W-1:0] CPOS_DATA  = 4'd12;  // first char of data/checksum
  localparam logic [CPOS_W-1:0] CPOS_MAX   = 4'd13;

  localparam logic [7:0] BLOCKS_MAX = 8'hFF;

  localparam int unsigned TDATA_W = 96;

  // Result payload without the kind, lowest field last
  typedef struct packed {
    logic        sticky_error;
    logic [7:0]  block_number;
    logic [31:0] block_end_address;
    logic        block_end_valid;
    logic        new_block;
    logic [7:0]  byte_count;
    logic [7:0]  data_value;
    logic [31:0] address;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [3:0] n;
    n = 4'd0;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      n = 4'(c - CHAR_0);
    end else if (c >= CHAR_A && c <= CHAR_F) begin
      n = 4'(c - CHAR_A + 8'd10);
    end
    return n;
  endfunction

  // data bytes in a record: count - 5, floored at zero
  function automatic logic [7:0] data_count(input logic [7:0] cnt);
    return (cnt >= HDR_BYTES) ? (cnt - HDR_BYTES) : 8'd0;
  endfunction

endpackage

`default_nettype wire

// ===== sv/srecord_s3_line_parser.sv =====
`default_nettype none

// S-record (S3 layout) line parser. Text arrives one character per input item
// (tdata = character, tlast = last character of the line, tuser = 1 for an
// end-of-file item, whose tdata is ignored). S0/S5 lines are skipped and make
// the next good record open a new block; S7 lines are skipped; every other line
// is parsed as count, 32-bit big-endian load address, data bytes and checksum.
// Each data byte comes out with its address, each record closes with an ok,
// mismatch or truncated result, and end of file always yields one result that
// carries the end address of the last block once a block is open and no error
// is set. Only '0'-'9' and 'A'-'F' are hex digits, anything else reads as zero.
// A mismatch or truncation sets a sticky error; text items then produce nothing
// until reset. Throughput is one item per clock while the downstream side is
// ready: each character is decoded and folded into the state as it is accepted,
// and a single output register holds the result so input keeps flowing;
// m_axis_tvalid_o rises in the cycle after accept. A character that completes no
// byte, or lies on a skipped line, gives no result unless it ends a record early.
module srecord_s3_line_parser (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // input characters
  input  wire logic                 s_axis_tvalid_i,
  output      logic                 s_axis_tready_o,
  input  wire logic [7:0]           s_axis_tdata_i,   // [7:0] text_char
  input  wire logic                 s_axis_tuser_i,   // [0] command
  input  wire logic                 s_axis_tlast_i,   // last_of_line
  // results
  output      logic                 m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // [31:0] address, [39:32] data_value, [47:40] byte_count, [48] new_block,
  // [49] block_end_valid, [81:50] block_end_address, [89:82] block_number,
  // [90] sticky_error, [95:91] zero
  output      logic [95:0]          m_axis_tdata_o,
  output      logic [2:0]           m_axis_tuser_o    // [2:0] result_kind
);
  import srec_pkg::*;

  // ---------------------------------------------------------------------------
  // Parser state
  // ---------------------------------------------------------------------------
  line_mode_e        mode_q,   mode_d, mode_mid;
  logic [CPOS_W-1:0] cpos_q,   cpos_d, cpos_mid;
  logic              pend_q,   pend_d, pend_mid;
  logic [3:0]        hi_q,     hi_d,   hi_mid;
  logic [7:0]        cnt_q,    cnt_d,  cnt_mid;
  logic [7:0]        sum_q,    sum_d,  sum_mid;
  logic [31:0]       load_q,   load_d, load_mid;
  logic [7:0]        dpos_q,   dpos_d, dpos_mid;
  logic [31:0]       lra_q,    lra_d;   // load address of the last good record
  logic              seen_q,   seen_d;
  logic [7:0]        blocks_q, blocks_d, blocks_mid;
  logic              err_q,    err_d,  err_mid;

  // output register
  logic              out_valid_q, out_valid_d;
  kind_e             kind_q,      kind_d;
  result_t           res_q,       res_d;

  // ---------------------------------------------------------------------------
  // Handshake and character decode
  // ---------------------------------------------------------------------------
  logic       in_fire, is_eof, text_ok;
  logic [3:0] nib;
  logic [7:0] byte_val;
  logic [7:0] dcnt_q;
  logic       in_rec, is_cnt, is_addr, is_ck, is_data, ck_ok, trunc;
  logic       open_blk, eof_valid, res_valid;

  // Output register frees up when the sink takes it, so a new item can enter
  // in the same cycle.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign is_eof          = in_fire && (s_axis_tuser_i == CMD_EOF);
  assign text_ok         = in_fire && (s_axis_tuser_i == CMD_CHAR) && !err_q;

  assign nib      = hex_nibble(s_axis_tdata_i);
  assign byte_val = {hi_q, nib};
  assign dcnt_q   = data_count(cnt_q);

  // An odd position inside a record closes a byte
  assign in_rec  = text_ok && (mode_q == LM_RECORD) && (cpos_q >= 4'd2) && cpos_q[0];
  assign is_cnt  = in_rec && (cpos_q == CPOS_COUNT);
  assign is_addr = in_rec && (cpos_q > CPOS_COUNT) && (cpos_q < CPOS_DATA);
  assign is_ck   = in_rec && (cpos_q >= CPOS_DATA) && (dpos_q >= dcnt_q);
  assign is_data = in_rec && (cpos_q >= CPOS_DATA) && (dpos_q < dcnt_q);
  assign ck_ok   = (byte_val == ~sum_q);

  assign open_blk  = is_ck && ck_ok && pend_q;
  assign eof_valid = (blocks_q != 8'd0) && seen_q && !err_q;

  // ---------------------------------------------------------------------------
  // Per-character update, before end-of-line handling
  // ---------------------------------------------------------------------------
  always_comb begin
    mode_mid   = mode_q;
    cpos_mid   = cpos_q;
    pend_mid   = pend_q;
    hi_mid     = hi_q;
    cnt_mid    = cnt_q;
    sum_mid    = sum_q;
    load_mid   = load_q;
    dpos_mid   = dpos_q;
    blocks_mid = blocks_q;
    err_mid    = err_q;
    if (text_ok) begin
      unique case (mode_q)
        LM_START: begin
          cnt_mid  = 8'd0;
          sum_mid  = 8'd0;
          load_mid = 32'd0;
          dpos_mid = 8'd0;
          hi_mid   = 4'd0;
          mode_mid = (s_axis_tdata_i == CHAR_S) ? LM_SAW_S : LM_RECORD;
          cpos_mid = 4'd1;
        end
        LM_SAW_S: begin
          if (s_axis_tdata_i == CHAR_0 || s_axis_tdata_i == CHAR_5) begin
            pend_mid = 1'b1;
            mode_mid = LM_SKIP;
          end else if (s_axis_tdata_i == CHAR_7) begin
            mode_mid = LM_SKIP;
          end else begin
            mode_mid = LM_RECORD;
          end
          cpos_mid = 4'd2;
        end
        LM_RECORD: begin
          if (cpos_q < 4'd2) begin
            cpos_mid = 4'd2;  // record line that did not start with 'S'
          end else if (!cpos_q[0]) begin
            hi_mid   = nib;
            cpos_mid = cpos_q + 4'd1;
          end else if (is_cnt) begin
            cnt_mid  = byte_val;
            sum_mid  = byte_val;
            cpos_mid = cpos_q + 4'd1;
          end else if (is_addr) begin
            load_mid = {load_q[23:0], byte_val};
            sum_mid  = sum_q + byte_val;
            cpos_mid = cpos_q + 4'd1;
          end else if (is_data) begin
            sum_mid  = sum_q + byte_val;
            dpos_mid = dpos_q + 8'd1;
            cpos_mid = CPOS_DATA;
          end else begin
            // checksum byte closes the record
            mode_mid = LM_SKIP;
            if (ck_ok) begin
              if (pend_q) begin
                pend_mid = 1'b0;
                if (blocks_q != BLOCKS_MAX) begin
                  blocks_mid = blocks_q + 8'd1;
                end
              end
            end else begin
              err_mid = 1'b1;
            end
          end
        end
        LM_SKIP: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Line ends before the checksum byte is complete
  assign trunc = text_ok && s_axis_tlast_i &&
                 (mode_mid == LM_SAW_S || mode_mid == LM_RECORD);

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    mode_d   = mode_mid;
    cpos_d   = cpos_mid;
    pend_d   = pend_mid;
    hi_d     = hi_mid;
    cnt_d    = cnt_mid;
    sum_d    = sum_mid;
    load_d   = load_mid;
    dpos_d   = dpos_mid;
    lra_d    = lra_q;
    seen_d   = seen_q;
    blocks_d = blocks_mid;
    err_d    = err_mid || trunc;
    if (is_ck && ck_ok) begin
      lra_d  = load_q;
      seen_d = 1'b1;
    end
    if (text_ok && s_axis_tlast_i) begin
      mode_d = LM_START;
      cpos_d = '0;
    end
    if (is_eof) begin
      // everything but the sticky error returns to its reset value
      mode_d   = LM_START;
      cpos_d   = '0;
      pend_d   = 1'b0;
      hi_d     = 4'd0;
      cnt_d    = 8'd0;
      sum_d    = 8'd0;
      load_d   = 32'd0;
      dpos_d   = 8'd0;
      lra_d    = 32'd0;
      seen_d   = 1'b0;
      blocks_d = 8'd0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result selection
  // ---------------------------------------------------------------------------
  assign res_valid = is_eof || trunc || is_ck || is_data;

  always_comb begin
    kind_d                  = KIND_DATA;
    res_d.address           = load_q + {24'd0, dpos_q};
    res_d.data_value        = byte_val;
    res_d.byte_count        = dcnt_q;
    res_d.new_block         = 1'b0;
    res_d.block_end_valid   = 1'b0;
    res_d.block_end_address = 32'd0;
    res_d.block_number      = blocks_mid;
    res_d.sticky_error      = err_mid || trunc;
    if (is_eof) begin
      kind_d                  = KIND_EOF;
      res_d.address           = eof_valid ? lra_q : 32'd0;
      res_d.data_value        = 8'd0;
      res_d.byte_count        = 8'd0;
      res_d.block_end_valid   = eof_valid;
      res_d.block_end_address = eof_valid ? lra_q : 32'd0;
      res_d.block_number      = blocks_q;
    end else if (trunc) begin
      // the byte this character may have finished is dropped
      kind_d           = KIND_TRUNC;
      res_d.address    = load_mid;
      res_d.data_value = 8'd0;
      res_d.byte_count = data_count(cnt_mid);
      res_d.new_block  = pend_mid;
    end else if (is_ck) begin
      res_d.address   = load_q;
      res_d.new_block = pend_q;
      if (ck_ok) begin
        kind_d                  = KIND_OK;
        res_d.block_end_valid   = open_blk && (blocks_q != 8'd0);
        res_d.block_end_address = (open_blk && (blocks_q != 8'd0)) ? lra_q : 32'd0;
      end else begin
        kind_d = KIND_MISMATCH;
      end
    end
  end

  // output register: load on a new result, hold while stalled
  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready_i;
    if (in_fire && res_valid) begin
      out_valid_d = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= LM_START;
      cpos_q      <= '0;
      pend_q      <= 1'b0;
      hi_q        <= 4'd0;
      cnt_q       <= 8'd0;
      sum_q       <= 8'd0;
      load_q      <= 32'd0;
      dpos_q      <= 8'd0;
      lra_q       <= 32'd0;
      seen_q      <= 1'b0;
      blocks_q    <= 8'd0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      cpos_q      <= cpos_d;
      pend_q      <= pend_d;
      hi_q        <= hi_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      load_q      <= load_d;
      dpos_q      <= dpos_d;
      lra_q       <= lra_d;
      seen_q      <= seen_d;
      blocks_q    <= blocks_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      kind_q <= kind_d;
      res_q  <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = kind_q;
  assign m_axis_tdata_o  = {(TDATA_W - RESULT_W)'(0), res_q};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // the error flag is sticky until reset
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |=> err_q)
    else $error("sticky error cleared");

  // only end of file can lower the block count
  a_blocks_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !is_eof |=> blocks_q >= $past(blocks_q))
    else $error("block count dropped");

  // a failing record result always carries the error flag
  a_fail_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (kind_q == KIND_MISMATCH || kind_q == KIND_TRUNC)
      |-> res_q.sticky_error)
    else $error("failed record without sticky error");

  // character position stays within the record layout
  a_cpos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cpos_q <= CPOS_MAX)
    else $error("character position out of range");

endmodule

`default_nettype wire
